// ===== rtl/core/tiny_mlp_velocity_scaler_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Tiny MLP velocity scaler: assertion macros
// Concurrent assertion shorthands clocked on clock, with and without reset.
// ----------------------------------------------------------------------------
`ifndef TINY_MLP_VELOCITY_SCALER_UNIT_MACROS_SVH
`define TINY_MLP_VELOCITY_SCALER_UNIT_MACROS_SVH

// checked outside reset
`define TMVS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define TMVS_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/tmvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Tiny MLP velocity scaler package
// Sizes, trained tables, sequencer codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package tmvs_pkg;

   localparam int HIDDEN_UNITS = 8;
   localparam int MAX_FEATURES = 4;
   localparam int IN_FIELDS    = 4;
   localparam int HID_AW  = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
   localparam int FEAT_AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int NF_W    = $clog2(MAX_FEATURES + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_FEATURES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_BIAS     = 2'd1;

   localparam logic [2:0]         ACTIVE_FEATURES_RST = 3'd4;
   localparam logic signed [31:0] OUTPUT_BIAS_RST     = 32'sd6553;

   localparam logic signed [31:0] SCALE_LOW  = 32'sd32768;
   localparam logic signed [31:0] SCALE_HIGH = 32'sd78643;

   // Q1.31 unity and tanh saturation point (8.0 in Q16.16)
   localparam logic [32:0] Q31_ONE   = 33'h0_8000_0000;
   localparam logic [32:0] TANH_SAT  = 33'd524288;
   localparam logic [16:0] TANH_FULL = 17'd65536;
   // reciprocal multipliers: x/5 = (x*R5)>>34, x/3 = (x*R3)>>33
   localparam logic signed [32:0] RECIP5 = 33'sh0_CCCC_CCCD;
   localparam logic signed [32:0] RECIP3 = 33'sh0_AAAA_AAAB;

   localparam int DIV_STEPS = 17;
   localparam int DIV_CNT_W = 5;

   // tanh micro-steps
   localparam int TS_W = 4;
   localparam logic [TS_W-1:0] TS_RECIP5   = 4'd0;
   localparam logic [TS_W-1:0] TS_QUARTER  = 4'd1;
   localparam logic [TS_W-1:0] TS_HOLD     = 4'd2;
   localparam logic [TS_W-1:0] TS_RECIP3   = 4'd3;
   localparam logic [TS_W-1:0] TS_HALF     = 4'd4;
   localparam logic [TS_W-1:0] TS_EXP      = 4'd5;
   localparam logic [TS_W-1:0] TS_SQ_FIRST = 4'd6;
   localparam logic [TS_W-1:0] TS_SQ_LAST  = 4'd13;

   localparam logic signed [31:0] IN_W [MAX_FEATURES*HIDDEN_UNITS] = '{
      32'sd32768,  32'sd6554,  -32'sd9830,  32'sd13107,
      -32'sd16384, 32'sd2621,  -32'sd5243,  32'sd7864,
      32'sd26214,  -32'sd19660, 32'sd9830,  -32'sd6553,
      32'sd5243,   -32'sd10486, 32'sd13107, -32'sd16384,
      32'sd3276,   -32'sd6553,  32'sd9830,  -32'sd13107,
      32'sd16384,  -32'sd2621,  32'sd5243,  -32'sd7864,
      -32'sd13107, 32'sd6553,   -32'sd3276, 32'sd6553,
      -32'sd9830,  32'sd13107,  -32'sd16384, 32'sd19660
   };
   localparam logic signed [31:0] HID_B [HIDDEN_UNITS] = '{
      32'sd0, 32'sd3276, -32'sd3276, 32'sd655,
      -32'sd1310, 32'sd1966, -32'sd2621, 32'sd3276
   };
   localparam logic signed [31:0] OUT_W [HIDDEN_UNITS] = '{
      32'sd9830, -32'sd6553, 32'sd3276, 32'sd6553,
      -32'sd9830, 32'sd13107, -32'sd16384, 32'sd19660
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_HID_INIT, ST_HID_MUL, ST_HID_ADD, ST_TANH_CHK,
      ST_TANH_MUL, ST_TANH_UPD, ST_DIV_GO, ST_DIV_RUN, ST_HID_WR,
      ST_OUT_RD, ST_OUT_MUL, ST_OUT_ADD, ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [47:0] num;
      logic [32:0] den;
   } div_req_type;

   function automatic logic signed [31:0] in_weight(
      input logic [FEAT_AW-1:0] f, input logic [HID_AW-1:0] h);
      return IN_W[int'(f) * HIDDEN_UNITS + int'(h)];
   endfunction

   // floor(p / 2^16), saturated to 32 bits
   function automatic logic signed [31:0] q16_from_prod(input logic signed [65:0] p);
      logic [18:0] hi;
      hi = p[65:47];
      if (hi == '0 || hi == '1) return p[47:16];
      else if (p[65]) return 32'sh8000_0000;
      else return 32'sh7FFF_FFFF;
   endfunction

   function automatic logic signed [31:0] sat_add(
      input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else return s[31:0];
   endfunction

endpackage

// ===== rtl/core/tiny_mlp_velocity_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// Tiny MLP velocity scaler
// Four Q16.16 features through eight tanh hidden units to a clamped scale.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// req      | req_valid/stall    | four signed Q16.16 features
// rsp      | rsp_valid/stall    | velocity_scale, 17-bit unsigned Q1.16
// csr      | csr_valid/ready    | csr_index, csr_wdata
//
// One item at a time through one shared multiplier and one divider.
// Per hidden unit the features are multiplied and summed, then tanh (skipped when |x| >= 8).
// The output layer then sums each hidden unit's weighted value onto the output bias.
// Reset restores the state, rsp_valid and the CSRs; the weight tables are constant.
// The next item is taken while a result waits under rsp_stall.
// ----------------------------------------------------------------------------
`include "tiny_mlp_velocity_scaler_unit_macros.svh"

module tiny_mlp_velocity_scaler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_feature_curvature,
   input  logic signed [31:0]                req_feature_arc_length,
   input  logic signed [31:0]                req_feature_target_velocity,
   input  logic signed [31:0]                req_feature_target_accel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [16:0]                       rsp_velocity_scale,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tmvs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);
   import tmvs_pkg::*;

   state_type state_ff, state_in;

   logic [2:0]         active_ff;
   logic signed [31:0] obias_ff;

   logic signed [31:0] feat_ff [IN_FIELDS];
   logic               feat_ld;
   logic [NF_W-1:0]    nf_ff, nf_in;
   logic [FEAT_AW-1:0] f_ff, f_in;
   logic [HID_AW-1:0]  h_ff, h_in;
   logic signed [31:0] acc_ff, acc_in;
   logic [32:0]        w_ff, w_in;
   logic [26:0]        u_ff, u_in;
   logic               neg_ff, neg_in;
   logic [16:0]        r_ff, r_in;
   logic [TS_W-1:0]    ts_ff, ts_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [16:0]        scale_ff, scale_in;

   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod;
   logic [32:0]        q31, q33, q34;
   logic [32:0]        mag;
   logic signed [31:0] hid_val;
   logic               ram_we;
   logic [31:0]        ram_rdata;
   div_req_type        div_req;
   logic               div_done;
   logic [16:0]        div_quo;
   logic [32:0]        one_minus_e;
   logic               h_last;
   logic               rsp_free;

   tmvs_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   tmvs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   tmvs_ram #(.WIDTH(32), .DEPTH(HIDDEN_UNITS)) u_hid_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (h_ff),
      .wr_data (hid_val),
      .rd_addr (h_ff),
      .rd_data (ram_rdata)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_velocity_scale = scale_ff;

   assign q31 = prod[63:31];
   assign q33 = prod[65:33];
   assign q34 = {1'b0, prod[65:34]};
   assign mag = acc_ff[31] ? 33'(33'sd0 - {acc_ff[31], acc_ff}) : {1'b0, acc_ff};
   assign hid_val = neg_ff ? 32'(32'sd0 - {15'd0, r_ff}) : {15'd0, r_ff};
   assign h_last = (h_ff == HID_AW'(HIDDEN_UNITS - 1));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign one_minus_e = Q31_ONE - w_ff;

   always_comb begin
      div_req.start = (state_ff == ST_DIV_GO);
      div_req.den   = Q31_ONE + w_ff;
      div_req.num   = {one_minus_e[31:0], 16'd0} + {16'd0, div_req.den[32:1]};
   end

   // multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_HID_MUL: begin
            op_a = {feat_ff[f_ff][31], feat_ff[f_ff]};
            op_b = 33'(in_weight(f_ff, h_ff));
         end
         ST_TANH_MUL: begin
            if (ts_ff == TS_RECIP3 || ts_ff >= TS_SQ_FIRST) op_a = w_ff;
            else op_a = {6'd0, u_ff};
            if (ts_ff == TS_RECIP5) op_b = RECIP5;
            else if (ts_ff == TS_RECIP3) op_b = RECIP3;
            else op_b = w_ff;
         end
         ST_OUT_MUL: begin
            op_a = {ram_rdata[31], ram_rdata};
            op_b = 33'(OUT_W[h_ff]);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      nf_in        = nf_ff;
      f_in         = f_ff;
      h_in         = h_ff;
      acc_in       = acc_ff;
      w_in         = w_ff;
      u_in         = u_ff;
      neg_in       = neg_ff;
      r_in         = r_ff;
      ts_in        = ts_ff;
      scale_in     = scale_ff;
      feat_ld      = 1'b0;
      ram_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               feat_ld  = 1'b1;
               nf_in    = (active_ff > 3'(MAX_FEATURES)) ? NF_W'(MAX_FEATURES)
                                                         : NF_W'(active_ff);
               h_in     = '0;
               state_in = ST_HID_INIT;
            end
         end
         ST_HID_INIT: begin
            acc_in   = HID_B[h_ff];
            f_in     = '0;
            state_in = (nf_ff == '0) ? ST_TANH_CHK : ST_HID_MUL;
         end
         ST_HID_MUL: state_in = ST_HID_ADD;
         ST_HID_ADD: begin
            acc_in = sat_add(acc_ff, q16_from_prod(prod));
            if (NF_W'(f_ff) == NF_W'(nf_ff - 1'b1)) begin
               state_in = ST_TANH_CHK;
            end else begin
               f_in     = f_ff + 1'b1;
               state_in = ST_HID_MUL;
            end
         end
         ST_TANH_CHK: begin
            neg_in = acc_ff[31];
            u_in   = {mag[18:0], 8'd0};
            ts_in  = TS_RECIP5;
            if (mag >= TANH_SAT) begin
               r_in     = TANH_FULL;
               state_in = ST_HID_WR;
            end else begin
               state_in = ST_TANH_MUL;
            end
         end
         ST_TANH_MUL: state_in = ST_TANH_UPD;
         ST_TANH_UPD: begin
            priority if (ts_ff == TS_RECIP5) w_in = Q31_ONE - q34;
            else if (ts_ff == TS_QUARTER)    w_in = Q31_ONE - (q31 >> 2);
            else if (ts_ff == TS_HOLD)       w_in = q31;
            else if (ts_ff == TS_RECIP3)     w_in = Q31_ONE - q33;
            else if (ts_ff == TS_HALF)       w_in = Q31_ONE - (q31 >> 1);
            else if (ts_ff == TS_EXP)        w_in = Q31_ONE - q31;
            else                             w_in = q31;
            if (ts_ff == TS_SQ_LAST) begin
               state_in = ST_DIV_GO;
            end else begin
               ts_in    = ts_ff + 1'b1;
               state_in = ST_TANH_MUL;
            end
         end
         ST_DIV_GO: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (div_done) begin
               r_in     = div_quo;
               state_in = ST_HID_WR;
            end
         end
         ST_HID_WR: begin
            ram_we = 1'b1;
            if (h_last) begin
               h_in     = '0;
               acc_in   = obias_ff;
               state_in = ST_OUT_RD;
            end else begin
               h_in     = h_ff + 1'b1;
               state_in = ST_HID_INIT;
            end
         end
         ST_OUT_RD:  state_in = ST_OUT_MUL;
         ST_OUT_MUL: state_in = ST_OUT_ADD;
         ST_OUT_ADD: begin
            acc_in = sat_add(acc_ff, q16_from_prod(prod));
            if (h_last) begin
               state_in = ST_DONE;
            end else begin
               h_in     = h_ff + 1'b1;
               state_in = ST_OUT_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               priority if (acc_ff < SCALE_LOW) scale_in = SCALE_LOW[16:0];
               else if (acc_ff > SCALE_HIGH)    scale_in = SCALE_HIGH[16:0];
               else                             scale_in = acc_ff[16:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACTIVE_FEATURES_RST;
         obias_ff     <= OUTPUT_BIAS_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == CSR_ACTIVE_FEATURES) begin
            active_ff <= csr_wdata[2:0];
         end
         if (csr_valid && csr_index == CSR_OUTPUT_BIAS) begin
            obias_ff <= csr_wdata;
         end
      end
      nf_ff    <= nf_in;
      f_ff     <= f_in;
      h_ff     <= h_in;
      acc_ff   <= acc_in;
      w_ff     <= w_in;
      u_ff     <= u_in;
      neg_ff   <= neg_in;
      r_ff     <= r_in;
      ts_ff    <= ts_in;
      scale_ff <= scale_in;
      if (feat_ld) begin
         feat_ff[0] <= req_feature_curvature;
         feat_ff[1] <= req_feature_arc_length;
         feat_ff[2] <= req_feature_target_velocity;
         feat_ff[3] <= req_feature_target_accel;
      end
   end

   `TMVS_ASSERT(a_scale_range, rsp_valid |-> (rsp_velocity_scale >= 17'd32768 && rsp_velocity_scale <= 17'd78643), "velocity scale out of clamp range")
   `TMVS_ASSERT(a_div_done_state, div_done |-> state_ff == ST_DIV_RUN, "divider finished outside its wait state")
   `TMVS_ASSERT(a_done_loads, (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff, "finished item not presented")
   `TMVS_ASSERT_NR(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset did not return to idle")
endmodule

// ===== rtl/core/tmvs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module tmvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/tmvs_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33x33 product, registered; the result appears in the cycle after the operands.
// ----------------------------------------------------------------------------
module tmvs_mul (
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [65:0] prod
);
   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

// ===== rtl/core/tmvs_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; the quotient is known to fit in 17 bits.
// ----------------------------------------------------------------------------
module tmvs_div (
   input  logic                      clock,
   input  logic                      reset,
   input  tmvs_pkg::div_req_type     req,
   output logic                      done,
   output logic [16:0]               quo
);
   import tmvs_pkg::*;

   logic [32:0]          rem_ff, rem_in;
   logic [16:0]          sh_ff, sh_in;
   logic [32:0]          den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [33:0]          trial;
   logic                 fits;

   assign trial = {rem_ff, sh_ff[16]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = {2'b00, req.num[47:17]};
         sh_in   = req.num[16:0];
         den_in  = req.den;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift quotient bits in behind the numerator bits
         rem_in = fits ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
         sh_in  = {sh_ff[15:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = sh_ff;
endmodule
